FILE: rtl/b64sd_pkg.sv
`default_nettype none

package b64sd_pkg;

  // Reset value of the output limit register.
  localparam logic [15:0] OUTPUT_LIMIT_RESET = 16'd1024;

  // Most bytes that one group of four characters can yield.
  localparam int unsigned GROUP_BYTES_MAX = 3;

  // Completed groups that can wait for the byte serialiser.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Slot index of the fourth character of a group.
  localparam logic [1:0] SLOT_FOURTH = 2'd3;

  // One input beat: a character of the encoded text.
  typedef struct packed {
    logic [7:0] char_code;
    logic       stream_last;
  } in_item_t;

  // One output beat: a decoded byte.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       group_last;
  } out_item_t;

  // Bytes of a finished group and how many of them are to be sent (1 to 3).
  typedef struct packed {
    logic [GROUP_BYTES_MAX-1:0][7:0] data_bytes;
    logic [1:0]                      byte_count;
  } group_t;

endpackage

`default_nettype wire

FILE: rtl/b64sd_group.sv
`default_nettype none

module b64sd_group (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_accept,
  input  wire b64sd_pkg::in_item_t item,
  input  wire logic              cfg_write,
  input  wire logic [15:0]       cfg_value,
  output b64sd_pkg::group_t      group,
  output logic                   group_push
);

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
  localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;

  // Returns {valid, sextet}; the sextet is zero for characters outside the alphabet.
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      d = c - CHAR_UPPER_A;
      return {1'b1, d[5:0]};
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      d = c - CHAR_LOWER_A + 8'd26;
      return {1'b1, d[5:0]};
    end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
      d = c - CHAR_DIGIT_0 + 8'd52;
      return {1'b1, d[5:0]};
    end else if (c == CHAR_PLUS) begin
      return {1'b1, 6'd62};
    end else if (c == CHAR_SLASH) begin
      return {1'b1, 6'd63};
    end
    return 7'd0;
  endfunction

  logic [15:0] output_limit;
  logic [5:0]  slot_values [3];
  logic [1:0]  slot_count;
  logic [2:0]  valid_count;
  logic [15:0] emitted_count;

  logic [5:0]  slot_values_next [3];
  logic [1:0]  slot_count_next;
  logic [2:0]  valid_count_next;
  logic [15:0] emitted_count_next;

  logic [6:0]  sextet;
  logic [5:0]  fourth_value;
  logic [5:0]  slot_upd [3];
  logic [2:0]  valid_upd;
  logic        may_run;
  logic        group_full;
  logic        group_ends;
  logic [1:0]  byte_count;
  logic [15:0] emitted_plus_one;
  logic [15:0] emitted_plus_n;

  always_comb begin
    sextet    = sextet_of(item.char_code);
    may_run   = (slot_count != 2'd0) ||
                (({1'b0, emitted_count} + 17'd3) < {1'b0, output_limit});
    valid_upd = valid_count + {2'b00, sextet[6]};
    group_full = (slot_count == b64sd_pkg::SLOT_FOURTH);
    for (int i = 0; i < 3; i++) begin
      slot_upd[i] = (slot_count == 2'(i)) ? sextet[5:0] : slot_values[i];
    end
    fourth_value = group_full ? sextet[5:0] : 6'd0;
    group_ends   = may_run && (group_full || item.stream_last);

    // The second and third bytes each need room below the limit.
    emitted_plus_one = emitted_count + 16'd1;
    byte_count = 2'd0;
    if (valid_upd >= 3'd2) begin
      byte_count = 2'd1;
    end
    if (valid_upd >= 3'd3 && emitted_plus_one < output_limit) begin
      byte_count = 2'd2;
    end
    emitted_plus_n = emitted_count + {14'd0, byte_count};
    if (valid_upd >= 3'd4 && byte_count != 2'd0 && emitted_plus_n < output_limit) begin
      byte_count = byte_count + 2'd1;
    end

    group.data_bytes[0] = {slot_upd[0], slot_upd[1][5:4]};
    group.data_bytes[1] = {slot_upd[1][3:0], slot_upd[2][5:2]};
    group.data_bytes[2] = {slot_upd[2][1:0], fourth_value};
    group.byte_count    = byte_count;
    group_push          = in_accept && group_ends && (byte_count != 2'd0);

    slot_values_next   = slot_values;
    slot_count_next    = slot_count;
    valid_count_next   = valid_count;
    emitted_count_next = emitted_count;
    if (in_accept) begin
      if (may_run) begin
        slot_values_next = slot_upd;
        slot_count_next  = slot_count + 2'd1;
        valid_count_next = valid_upd;
        if (group_ends) begin
          for (int i = 0; i < 3; i++) begin
            slot_values_next[i] = 6'd0;
          end
          slot_count_next    = 2'd0;
          valid_count_next   = 3'd0;
          emitted_count_next = emitted_count + {14'd0, byte_count};
        end
      end
      if (item.stream_last) begin
        for (int i = 0; i < 3; i++) begin
          slot_values_next[i] = 6'd0;
        end
        slot_count_next    = 2'd0;
        valid_count_next   = 3'd0;
        emitted_count_next = 16'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      output_limit  <= b64sd_pkg::OUTPUT_LIMIT_RESET;
      for (int i = 0; i < 3; i++) begin
        slot_values[i] <= 6'd0;
      end
      slot_count    <= 2'd0;
      valid_count   <= 3'd0;
      emitted_count <= 16'd0;
    end else begin
      if (cfg_write) begin
        output_limit <= cfg_value;
      end
      slot_values   <= slot_values_next;
      slot_count    <= slot_count_next;
      valid_count   <= valid_count_next;
      emitted_count <= emitted_count_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/b64sd_queue.sv
`default_nettype none

module b64sd_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire b64sd_pkg::group_t   push_group,
  output logic                     full,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output b64sd_pkg::out_item_t     out_data
);

  localparam int unsigned PTR_W   = (b64sd_pkg::QUEUE_DEPTH > 1) ?
                                    $clog2(b64sd_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned COUNT_W = $clog2(b64sd_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0]   PTR_LAST = PTR_W'(b64sd_pkg::QUEUE_DEPTH - 1);
  localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(b64sd_pkg::QUEUE_DEPTH);

  b64sd_pkg::group_t entries [b64sd_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [COUNT_W-1:0] count;
  logic [1:0]         byte_idx;

  b64sd_pkg::group_t head;
  logic              head_last;
  logic              pop_byte;
  logic              pop_entry;

  always_comb begin
    head      = entries[rd_ptr];
    head_last = (byte_idx == (head.byte_count - 2'd1));
    out_valid = (count != '0);
    full      = (count == COUNT_FULL);
    pop_byte  = out_valid && !out_stall;
    pop_entry = pop_byte && head_last;
    unique case (byte_idx)
      2'd0:    out_data.data_byte = head.data_bytes[0];
      2'd1:    out_data.data_byte = head.data_bytes[1];
      2'd2:    out_data.data_byte = head.data_bytes[2];
      default: out_data.data_byte = 8'd0;
    endcase
    out_data.group_last = head_last;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_group;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      count    <= '0;
      byte_idx <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop_entry) begin
        rd_ptr   <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
        byte_idx <= 2'd0;
      end else if (pop_byte) begin
        byte_idx <= byte_idx + 2'd1;
      end
      count <= count + COUNT_W'(push) - COUNT_W'(pop_entry);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/base64_stream_decoder.sv
`default_nettype none

// Base64 stream decoder. Characters arrive one per input beat and are decoded
// at the full input rate: one character is taken in every clock cycle while
// the output side keeps up, and each decoded byte leaves as one output beat.
// Characters are gathered in groups of four; a group closes after its fourth
// character or at the character marked stream_last, and then yields up to three
// bytes, one fewer than the number of its characters that belonged to the
// standard alphabet ('=' and all other codes count as zero and not valid).
// The rate is set by the output port, which sends one byte per cycle while out_stall
// is low: a finished group waits in a two-entry queue, and the input stalls only
// while both entries are taken. The output_limit register caps the bytes sent per
// stream (no group starts once the count reaches output_limit minus three);
// it resets to 1024 and should be written only while the decoder is idle.
// Reset is synchronous; no clearing pass follows it.

module base64_stream_decoder (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // Character input channel.
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire b64sd_pkg::in_item_t  in_data,
  // Decoded byte output channel.
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output b64sd_pkg::out_item_t      out_data,
  // Write port of the output_limit register.
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [15:0]          cfg_data
);

  logic              in_accept;
  logic              queue_full;
  logic              group_push;
  b64sd_pkg::group_t group;

  // The register can always take a write; writes are expected only when idle.
  assign cfg_ready = 1'b1;

  // A character is taken whenever the queue has room for the group it may close.
  assign in_stall  = queue_full;
  assign in_accept = in_valid && !queue_full;

  // Group assembly: slot values, counters and the byte build for one character.
  b64sd_group u_group (
    .clk        (clk),
    .rst        (rst),
    .in_accept  (in_accept),
    .item       (in_data),
    .cfg_write  (cfg_valid && cfg_ready),
    .cfg_value  (cfg_data),
    .group      (group),
    .group_push (group_push)
  );

  // Finished groups wait here and are sent one byte per beat, the last byte
  // of each group flagged with group_last.
  b64sd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (group_push),
    .push_group (group),
    .full       (queue_full),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

FILE: rtl/b64sd_checker.sv
`default_nettype none

module b64sd_checker (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 in_stall,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire b64sd_pkg::out_item_t out_data
);

  // A stalled output beat keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  // The input only stalls when a finished group is waiting to be sent.
  a_stall_has_output: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with nothing to send");

  // A group is sent as an unbroken run of bytes.
  a_group_unbroken: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !out_data.group_last |=> out_valid)
    else $error("gap inside a group's bytes");

  // Reset empties the output.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output beat offered straight after reset");

endmodule

bind base64_stream_decoder b64sd_checker u_checker (.*);

`default_nettype wire
